### rtl/core/tgd_pkg.sv
// package: shared constants, codes and types of the touch gesture detector
`timescale 1ns / 1ps

package tgd_pkg;

    localparam int HISTORY_DEPTH = 20;
    localparam int SCREEN_WIDTH  = 480;
    localparam int SCREEN_HEIGHT = 320;

    localparam int PTR_W  = $clog2(HISTORY_DEPTH);
    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W  = PTR_W + 1;

    localparam int MIN_SWIPE_POINTS = 3;

    localparam logic [15:0] RST_LONG_PRESS_MS = 16'd500;
    localparam logic [15:0] RST_DOUBLE_TAP_MS = 16'd300;
    localparam logic [9:0]  RST_SWIPE_THRESH  = 10'd30;
    localparam logic [7:0]  RST_SCAN_INTERVAL = 8'd20;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_PRESS   = 2'd1,
        OP_MOVE    = 2'd2,
        OP_RELEASE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_MOVE    = 2'd2,
        EV_RELEASE = 2'd3
    } event_t;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_PRESSED  = 2'd1,
        PH_HELD     = 2'd2,
        PH_RELEASED = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        G_NONE   = 3'd0,
        G_TAP    = 3'd1,
        G_DOUBLE = 3'd2,
        G_LONG   = 3'd3,
        G_LEFT   = 3'd4,
        G_RIGHT  = 3'd5,
        G_UP     = 3'd6,
        G_DOWN   = 3'd7
    } gesture_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GESTURES_ENABLE = 3'd0,
        CFG_SWAP_AXES       = 3'd1,
        CFG_MIRROR_X        = 3'd2,
        CFG_MIRROR_Y        = 3'd3,
        CFG_LONG_PRESS_MS   = 3'd4,
        CFG_DOUBLE_TAP_MS   = 3'd5,
        CFG_SWIPE_THRESHOLD = 3'd6,
        CFG_SCAN_INTERVAL   = 3'd7
    } cfg_idx_t;

endpackage

### rtl/core/tgd_item_if.sv
// interface: input item channel
`timescale 1ns / 1ps

interface tgd_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [15:0] x_in;
    logic [15:0] y_in;
    logic [31:0] now_ms;

    modport source (output valid, output operation, output x_in, output y_in,
                    output now_ms, input ready);
    modport sink (input valid, input operation, input x_in, input y_in,
                  input now_ms, output ready);
endinterface

### rtl/core/tgd_result_if.sv
// interface: result item channel
`timescale 1ns / 1ps

interface tgd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_code;
    logic [1:0]  touch_phase;
    logic [2:0]  gesture_code;
    logic        gesture_new;
    logic [15:0] point_x;
    logic [15:0] point_y;
    logic        is_active;
    logic [31:0] press_total;

    modport source (output valid, output event_code, output touch_phase,
                    output gesture_code, output gesture_new, output point_x,
                    output point_y, output is_active, output press_total,
                    input ready);
    modport sink (input valid, input event_code, input touch_phase,
                  input gesture_code, input gesture_new, input point_x,
                  input point_y, input is_active, input press_total,
                  output ready);
endinterface

### rtl/core/tgd_cfg_if.sv
// interface: configuration register write channel
`timescale 1ns / 1ps

interface tgd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tgd_pkg::CFG_IDX_W-1:0]  index;
    logic [tgd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/touch_gesture_detector_unit.sv
// top level: single-touch gesture detector with history ring memory
`timescale 1ns / 1ps

// Takes one tick, press, move or release item per clock while the output
// side is not stalled and returns exactly one result per item. The first
// stage orients the point, screens it, keeps the touch flag and ring
// pointers, writes the point into the history ring memory and reads the
// oldest stored point in the same cycle; the second stage uses that
// registered read data with the time and gesture state to build the result
// in the output register. The ring memory has one write and one read port,
// so one item per cycle is the sustained rate when the output side is not
// stalled. The ring needs no clearing after reset: the fill count keeps
// every read whose data is used on a written entry. Configuration writes
// are taken at any time and must only be issued while no item is in flight.
module touch_gesture_detector_unit (
    input  logic         clk,
    input  logic         rst_n,
    tgd_item_if.sink     item,
    tgd_result_if.source result,
    tgd_cfg_if.sink      cfg
);
    import tgd_pkg::*;

    // configuration
    logic        gestures_enable_reg;
    logic        swap_axes_reg;
    logic        mirror_x_reg;
    logic        mirror_y_reg;
    logic [15:0] long_press_ms_reg;
    logic [15:0] double_tap_ms_reg;
    logic [9:0]  swipe_threshold_reg;
    logic [7:0]  scan_interval_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gestures_enable_reg <= 1'b1;
            swap_axes_reg       <= 1'b0;
            mirror_x_reg        <= 1'b0;
            mirror_y_reg        <= 1'b0;
            long_press_ms_reg   <= RST_LONG_PRESS_MS;
            double_tap_ms_reg   <= RST_DOUBLE_TAP_MS;
            swipe_threshold_reg <= RST_SWIPE_THRESH;
            scan_interval_reg   <= RST_SCAN_INTERVAL;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_GESTURES_ENABLE: gestures_enable_reg <= cfg.data[0];
                CFG_SWAP_AXES:       swap_axes_reg       <= cfg.data[0];
                CFG_MIRROR_X:        mirror_x_reg        <= cfg.data[0];
                CFG_MIRROR_Y:        mirror_y_reg        <= cfg.data[0];
                CFG_LONG_PRESS_MS:   long_press_ms_reg   <= cfg.data;
                CFG_DOUBLE_TAP_MS:   double_tap_ms_reg   <= cfg.data;
                CFG_SWIPE_THRESHOLD: swipe_threshold_reg <= cfg.data[9:0];
                CFG_SCAN_INTERVAL:   scan_interval_reg   <= cfg.data[7:0];
                default:             ;
            endcase
        end
    end

    // pipeline handshake
    logic p1_valid_reg;
    logic res_valid_reg;
    logic out_free;
    logic s1_go;
    logic acc;

    assign out_free   = !res_valid_reg || result.ready;
    assign s1_go      = p1_valid_reg && out_free;
    assign item.ready = !p1_valid_reg || out_free;
    assign acc        = item.valid && item.ready;

    // stage 0: orientation, screening, ring pointers
    op_t               op_in;
    logic [15:0]       sx;
    logic [15:0]       sy;
    logic [15:0]       ox;
    logic [15:0]       oy;
    logic              on_screen;
    logic              point_ok;
    logic              rel_ok;
    logic              swipe_chk;
    logic              fe_active_reg;
    logic              fe_active_next;
    logic [PTR_W-1:0]  wr_pos_reg;
    logic [PTR_W-1:0]  wr_pos_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [SUM_W-1:0]  rd_sum;
    logic [PTR_W-1:0]  rd_idx;

    always_comb
    begin
        op_in = op_t'(item.operation);
        sx    = swap_axes_reg ? item.y_in : item.x_in;
        sy    = swap_axes_reg ? item.x_in : item.y_in;
        ox    = mirror_x_reg ? 16'(SCREEN_WIDTH - 1) - sx : sx;
        oy    = mirror_y_reg ? 16'(SCREEN_HEIGHT - 1) - sy : sy;
        on_screen = (ox < 16'(SCREEN_WIDTH)) && (oy < 16'(SCREEN_HEIGHT));
        point_ok  = on_screen
                    && (op_in == OP_PRESS || (op_in == OP_MOVE && fe_active_reg));
        rel_ok    = (op_in == OP_RELEASE) && fe_active_reg;

        fe_active_next = fe_active_reg;
        if (point_ok && op_in == OP_PRESS)
        begin
            fe_active_next = 1'b1;
        end
        else if (rel_ok)
        begin
            fe_active_next = 1'b0;
        end

        wr_pos_next = wr_pos_reg;
        fill_next   = fill_reg;
        if (point_ok)
        begin
            wr_pos_next = (wr_pos_reg == PTR_W'(HISTORY_DEPTH - 1))
                          ? '0 : wr_pos_reg + 1'b1;
            if (fill_reg < FILL_W'(HISTORY_DEPTH))
            begin
                fill_next = fill_reg + 1'b1;
            end
        end

        swipe_chk = point_ok && (op_in == OP_MOVE) && gestures_enable_reg
                    && (fill_next >= FILL_W'(MIN_SWIPE_POINTS));

        // oldest stored point after this push
        rd_sum = SUM_W'(wr_pos_next) + SUM_W'(HISTORY_DEPTH) - SUM_W'(fill_next);
        rd_idx = (rd_sum >= SUM_W'(HISTORY_DEPTH))
                 ? PTR_W'(rd_sum - SUM_W'(HISTORY_DEPTH)) : PTR_W'(rd_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fe_active_reg <= 1'b0;
            wr_pos_reg    <= '0;
            fill_reg      <= '0;
        end
        else if (acc)
        begin
            fe_active_reg <= fe_active_next;
            wr_pos_reg    <= wr_pos_next;
            fill_reg      <= fill_next;
        end
    end

    // history ring: only the first point reads the entry written in the same
    // cycle, and its read data is never used
    logic [31:0] hist_mem [HISTORY_DEPTH];
    logic [31:0] hist_rd_reg;

    always_ff @(posedge clk)
    begin
        if (acc && point_ok)
        begin
            hist_mem[wr_pos_reg] <= {oy, ox};
        end
        if (acc)
        begin
            hist_rd_reg <= hist_mem[rd_idx];
        end
    end

    // stage 1 pipeline registers
    op_t         p1_op_reg;
    logic [15:0] p1_x_reg;
    logic [15:0] p1_y_reg;
    logic        p1_point_ok_reg;
    logic        p1_rel_ok_reg;
    logic        p1_swipe_reg;
    logic        p1_active_reg;
    logic [31:0] p1_now_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else if (acc)
        begin
            p1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            p1_op_reg       <= op_in;
            p1_x_reg        <= ox;
            p1_y_reg        <= oy;
            p1_point_ok_reg <= point_ok;
            p1_rel_ok_reg   <= rel_ok;
            p1_swipe_reg    <= swipe_chk;
            p1_active_reg   <= fe_active_next;
            p1_now_reg      <= item.now_ms;
        end
    end

    // stage 1: timing, gestures, result
    phase_t      phase_reg;
    phase_t      phase_next;
    gesture_t    gesture_reg;
    gesture_t    gesture_next;
    logic [31:0] press_count_reg;
    logic [31:0] press_count_next;
    logic [31:0] press_start_reg;
    logic [31:0] press_start_next;
    logic [31:0] last_tap_reg;
    logic [31:0] last_tap_next;
    logic [31:0] last_scan_reg;
    logic [31:0] last_scan_next;
    logic [15:0] cur_x_reg;
    logic [15:0] cur_x_next;
    logic [15:0] cur_y_reg;
    logic [15:0] cur_y_next;
    event_t      ev;
    logic        gnew;
    logic [31:0] hold;
    logic [31:0] since_tap;
    logic [31:0] since_scan;
    logic [16:0] dx;
    logic [16:0] dy;
    logic [16:0] ax;
    logic [16:0] ay;
    logic [16:0] th;
    gesture_t    swipe_dir;

    always_comb
    begin
        hold       = p1_now_reg - press_start_reg;
        since_tap  = p1_now_reg - last_tap_reg;
        since_scan = p1_now_reg - last_scan_reg;

        dx = {1'b0, p1_x_reg} - {1'b0, hist_rd_reg[15:0]};
        dy = {1'b0, p1_y_reg} - {1'b0, hist_rd_reg[31:16]};
        ax = dx[16] ? 17'(-dx) : dx;
        ay = dy[16] ? 17'(-dy) : dy;
        th = 17'(swipe_threshold_reg);
        if (ax > ay)
        begin
            swipe_dir = (!dx[16] && dx != '0) ? G_RIGHT : G_LEFT;
        end
        else
        begin
            swipe_dir = (!dy[16] && dy != '0) ? G_DOWN : G_UP;
        end

        phase_next       = phase_reg;
        gesture_next     = gesture_reg;
        press_count_next = press_count_reg;
        press_start_next = press_start_reg;
        last_tap_next    = last_tap_reg;
        last_scan_next   = last_scan_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        ev               = EV_NONE;
        gnew             = 1'b0;

        unique case (p1_op_reg)
            OP_TICK:
            begin
                if (since_scan >= 32'(scan_interval_reg))
                begin
                    last_scan_next = p1_now_reg;
                    if (!p1_active_reg)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else if (gestures_enable_reg && hold > 32'(long_press_ms_reg)
                             && gesture_reg != G_LONG)
                    begin
                        gesture_next = G_LONG;
                        gnew         = 1'b1;
                    end
                end
            end
            OP_RELEASE:
            begin
                if (p1_rel_ok_reg)
                begin
                    phase_next = PH_RELEASED;
                    ev         = EV_RELEASE;
                    cur_x_next = p1_x_reg;
                    cur_y_next = p1_y_reg;
                    if (gestures_enable_reg)
                    begin
                        if (hold < 32'(double_tap_ms_reg))
                        begin
                            gesture_next  = G_TAP;
                            last_tap_next = p1_now_reg;
                            gnew          = 1'b1;
                        end
                        else if (hold > 32'(long_press_ms_reg))
                        begin
                            gesture_next = G_LONG;
                            gnew         = 1'b1;
                        end
                    end
                end
            end
            OP_PRESS:
            begin
                if (p1_point_ok_reg)
                begin
                    phase_next       = PH_PRESSED;
                    ev               = EV_PRESS;
                    cur_x_next       = p1_x_reg;
                    cur_y_next       = p1_y_reg;
                    press_count_next = press_count_reg + 32'd1;
                    press_start_next = p1_now_reg;
                    if (since_tap < 32'(double_tap_ms_reg))
                    begin
                        gesture_next = G_DOUBLE;
                        gnew         = 1'b1;
                    end
                end
            end
            OP_MOVE:
            begin
                if (p1_point_ok_reg)
                begin
                    phase_next = PH_HELD;
                    ev         = EV_MOVE;
                    cur_x_next = p1_x_reg;
                    cur_y_next = p1_y_reg;
                    if (p1_swipe_reg && (ax > th || ay > th)
                        && swipe_dir != gesture_reg)
                    begin
                        gesture_next = swipe_dir;
                        gnew         = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            gesture_reg     <= G_NONE;
            press_count_reg <= '0;
            press_start_reg <= '0;
            last_tap_reg    <= '0;
            last_scan_reg   <= '0;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
        end
        else if (s1_go)
        begin
            phase_reg       <= phase_next;
            gesture_reg     <= gesture_next;
            press_count_reg <= press_count_next;
            press_start_reg <= press_start_next;
            last_tap_reg    <= last_tap_next;
            last_scan_reg   <= last_scan_next;
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
        end
    end

    // output register
    event_t      res_event_reg;
    logic        res_gnew_reg;
    logic        res_active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            res_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            res_event_reg  <= ev;
            res_gnew_reg   <= gnew;
            res_active_reg <= p1_active_reg;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.event_code   = res_event_reg;
    assign result.touch_phase  = phase_reg;
    assign result.gesture_code = gesture_reg;
    assign result.gesture_new  = res_gnew_reg;
    assign result.point_x      = cur_x_reg;
    assign result.point_y      = cur_y_reg;
    assign result.is_active    = res_active_reg;
    assign result.press_total  = press_count_reg;

endmodule

### rtl/core/tgd_checker.sv
// checker: port-level assertions for the touch gesture detector, with bind
`timescale 1ns / 1ps

module tgd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [1:0]  event_code,
    input logic [1:0]  touch_phase,
    input logic [2:0]  gesture_code,
    input logic        gesture_new,
    input logic        is_active,
    input logic [31:0] press_total
);
    import tgd_pkg::*;

    // stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(event_code)
            && $stable(press_total) && $stable(gesture_code))
        else $error("result changed while stalled");

    a_press_state: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && event_code == EV_PRESS |-> is_active
            && touch_phase == PH_PRESSED)
        else $error("press without active pressed phase");

    a_release_state: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && event_code == EV_RELEASE |-> !is_active
            && touch_phase == PH_RELEASED)
        else $error("release without released phase");

    a_move_state: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && event_code == EV_MOVE |-> is_active && touch_phase == PH_HELD)
        else $error("move outside a held touch");

    a_gesture_new: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && gesture_new |-> gesture_code != G_NONE)
        else $error("new gesture flagged with no gesture");

endmodule

bind touch_gesture_detector_unit tgd_checker u_tgd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .event_code   (result.event_code),
    .touch_phase  (result.touch_phase),
    .gesture_code (result.gesture_code),
    .gesture_new  (result.gesture_new),
    .is_active    (result.is_active),
    .press_total  (result.press_total)
);
